// ===== rtl/core/ste_pkg.sv =====
// Shared types and constants of the speech text escaper.
`timescale 1ns / 1ps

package ste_pkg;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_BTICK = 8'h60;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_PIPE  = 8'h7C;

	// Output form of one processed byte.
	typedef enum logic [2:0] {
		KIND_RAW,    // the byte itself
		KIND_ESC3,   // backslash, byte, space
		KIND_CARET,  // backslash, backslash, caret, space
		KIND_BSL4,   // four backslashes
		KIND_END     // empty end marker
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic       last;
	} cmd_t;

endpackage

// ===== rtl/core/ste_front.sv =====
// Front part: accepts and cleans bytes, runs the lookahead escaping decisions.
`timescale 1ns / 1ps

module ste_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_write,
	input  logic           cfg_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	input  logic           q_full,
	output logic           q_push,
	output ste_pkg::cmd_t  q_cmd
);

	localparam logic ST_RUN   = 1'b0;
	localparam logic ST_FLUSH = 1'b1;

	typedef struct packed {
		logic                emit;
		ste_pkg::cmd_kind_t  kind;
		logic [7:0]          data;
		logic [7:0]          kept;
		logic                start;
		logic                esc;
	} proc_t;

	function automatic logic [7:0] clean(input logic [7:0] b);
		logic [7:0] r;
		begin
			r = b;
			if (b < 8'd32 && b != ste_pkg::CH_NL) r = ste_pkg::CH_SP;
			else if (b == 8'd127) r = ste_pkg::CH_SP;
			else if (b == 8'd145 || b == 8'd146) r = ste_pkg::CH_APOS;
			else if ((b >= 8'd129 && b <= 8'd132) || (b >= 8'd134 && b <= 8'd137) ||
					b == 8'd139 || (b >= 8'd141 && b <= 8'd144) || b == 8'd155 ||
					(b >= 8'd157 && b <= 8'd159) || b == 8'd255)
				r = ste_pkg::CH_SP;
			return r;
		end
	endfunction

	function automatic ste_pkg::cmd_kind_t esc_kind(input logic [7:0] c);
		ste_pkg::cmd_kind_t k;
		begin
			k = ste_pkg::KIND_RAW;
			if (c == ste_pkg::CH_PIPE || c == ste_pkg::CH_BTICK) k = ste_pkg::KIND_ESC3;
			else if (c == ste_pkg::CH_CARET) k = ste_pkg::KIND_CARET;
			else if (c == ste_pkg::CH_BSL) k = ste_pkg::KIND_BSL4;
			return k;
		end
	endfunction

	// Decision for the byte at the head of the window, with two bytes of lookahead.
	function automatic proc_t do_proc(input logic mode, input logic [7:0] kept,
			input logic start, input logic esc, input logic [7:0] h_in,
			input logic [7:0] a1, input logic [7:0] a2);
		proc_t      r;
		logic [7:0] h;
		begin
			r.emit  = 1'b0;
			r.kind  = ste_pkg::KIND_RAW;
			r.data  = h_in;
			r.kept  = kept;
			r.start = start;
			r.esc   = esc;
			h       = h_in;
			if (esc) begin
				// This byte was already written out by the preceding backslash.
				r.esc   = 1'b0;
				r.kept  = h_in;
				r.start = 1'b0;
			end else if (h_in == ste_pkg::CH_NL && !start && kept == ste_pkg::CH_SP) begin
				r.kept = ste_pkg::CH_NL;
			end else begin
				if (h_in == ste_pkg::CH_NL) h = ste_pkg::CH_SP;
				r.start = 1'b0;
				r.kept  = h;
				r.emit  = 1'b1;
				r.data  = h;
				r.kind  = esc_kind(h);
				if (mode && h == ste_pkg::CH_BSL &&
						(a1 == ste_pkg::CH_BSL || a1 == ste_pkg::CH_BTICK)) begin
					r.esc  = 1'b1;
					r.data = a1;
					r.kind = esc_kind(a1);
				end else if (mode && h == ste_pkg::CH_BTICK) begin
					if (a1 == ste_pkg::CH_G || a1 == ste_pkg::CH_I ||
							(a1 == ste_pkg::CH_U && a2 == ste_pkg::CH_I))
						r.kind = ste_pkg::KIND_ESC3;
					else
						r.kind = ste_pkg::KIND_RAW;
				end
			end
			return r;
		end
	endfunction

	logic                state_q;
	logic                mode_q;
	logic [7:0]          win_q [3];
	logic [1:0]          cnt_q;
	logic [7:0]          kept_q;
	logic                start_q;
	logic                esc_q;
	logic                hold_vld_q;
	ste_pkg::cmd_t       hold_q;

	logic                in_take;
	logic                flush_go;
	logic [7:0]          cleaned;
	logic [7:0]          fl_a1;
	logic [7:0]          fl_a2;
	proc_t               pr_run;
	proc_t               pr_fl;
	ste_pkg::cmd_t       fl_cmd;

	assign in_stall = (state_q != ST_RUN) || q_full;
	assign in_take  = in_valid && !in_stall;
	assign flush_go = (state_q == ST_FLUSH) && !q_full;
	assign cleaned  = clean(in_byte);

	assign fl_a1 = (cnt_q > 2'd1) ? win_q[1] : ste_pkg::CH_NUL;
	assign fl_a2 = (cnt_q > 2'd2) ? win_q[2] : ste_pkg::CH_NUL;

	assign pr_run = do_proc(mode_q, kept_q, start_q, esc_q, win_q[0], win_q[1], cleaned);
	assign pr_fl  = do_proc(mode_q, kept_q, start_q, esc_q, win_q[0], fl_a1, fl_a2);

	always_comb begin
		fl_cmd.kind = pr_fl.kind;
		fl_cmd.data = pr_fl.data;
		fl_cmd.last = 1'b0;
	end

	always_comb begin
		q_push = 1'b0;
		q_cmd.kind = pr_run.kind;
		q_cmd.data = pr_run.data;
		q_cmd.last = 1'b0;
		if (in_take && !in_last && cnt_q == 2'd2 && pr_run.emit) begin
			q_push = 1'b1;
		end else if (flush_go) begin
			if (cnt_q != 2'd0) begin
				// Hold one command back so the final one can carry the last flag.
				q_push = pr_fl.emit && hold_vld_q;
				q_cmd  = hold_q;
			end else begin
				q_push = 1'b1;
				if (hold_vld_q) begin
					q_cmd      = hold_q;
					q_cmd.last = 1'b1;
				end else begin
					q_cmd.kind = ste_pkg::KIND_END;
					q_cmd.data = ste_pkg::CH_NUL;
					q_cmd.last = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			mode_q     <= 1'b0;
			cnt_q      <= 2'd0;
			kept_q     <= 8'd0;
			start_q    <= 1'b1;
			esc_q      <= 1'b0;
			hold_vld_q <= 1'b0;
		end else begin
			if (cfg_write) mode_q <= cfg_data;
			if (in_take) begin
				if (!in_last) begin
					if (cnt_q == 2'd2) begin
						kept_q  <= pr_run.kept;
						start_q <= pr_run.start;
						esc_q   <= pr_run.esc;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end else begin
					cnt_q   <= cnt_q + 2'd1;
					state_q <= ST_FLUSH;
				end
			end
			if (flush_go) begin
				if (cnt_q != 2'd0) begin
					kept_q  <= pr_fl.kept;
					start_q <= pr_fl.start;
					esc_q   <= pr_fl.esc;
					cnt_q   <= cnt_q - 2'd1;
					if (pr_fl.emit) hold_vld_q <= 1'b1;
				end else begin
					kept_q     <= 8'd0;
					start_q    <= 1'b1;
					esc_q      <= 1'b0;
					hold_vld_q <= 1'b0;
					state_q    <= ST_RUN;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			if (!in_last && cnt_q == 2'd2) begin
				win_q[0] <= win_q[1];
				win_q[1] <= cleaned;
			end else begin
				win_q[cnt_q] <= cleaned;
			end
		end
		if (flush_go && cnt_q != 2'd0) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			if (pr_fl.emit) hold_q <= fl_cmd;
		end
	end

endmodule

// ===== rtl/core/ste_queue.sv =====
// Short command queue between the front and the back part.
`timescale 1ns / 1ps

module ste_queue #(
	parameter int DEPTH = ste_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ste_pkg::cmd_t  push_cmd,
	output logic           full,
	input  logic           pop,
	output ste_pkg::cmd_t  head,
	output logic           empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

	ste_pkg::cmd_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_MAX);
	assign empty   = (count_q == '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/core/ste_back.sv =====
// Back part: expands queued commands into output bytes, one per cycle unless the output stalls.
`timescale 1ns / 1ps

module ste_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ste_pkg::cmd_t  head,
	input  logic           empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           out_has_byte,
	output logic           out_last
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_has_q;
	logic       out_last_q;
	logic [1:0] idx_q;

	logic       take;
	logic [1:0] last_idx;
	logic       at_end;
	logic [7:0] gen_byte;

	always_comb begin
		last_idx = 2'd0;
		gen_byte = head.data;
		unique case (head.kind)
			ste_pkg::KIND_RAW: begin
				last_idx = 2'd0;
				gen_byte = head.data;
			end
			ste_pkg::KIND_ESC3: begin
				last_idx = 2'd2;
				gen_byte = (idx_q == 2'd0) ? ste_pkg::CH_BSL :
						(idx_q == 2'd1) ? head.data : ste_pkg::CH_SP;
			end
			ste_pkg::KIND_CARET: begin
				last_idx = 2'd3;
				gen_byte = (idx_q[1] == 1'b0) ? ste_pkg::CH_BSL :
						(idx_q == 2'd2) ? ste_pkg::CH_CARET : ste_pkg::CH_SP;
			end
			ste_pkg::KIND_BSL4: begin
				last_idx = 2'd3;
				gen_byte = ste_pkg::CH_BSL;
			end
			ste_pkg::KIND_END: begin
				last_idx = 2'd0;
				gen_byte = ste_pkg::CH_NUL;
			end
			default: begin
				last_idx = 2'd0;
				gen_byte = ste_pkg::CH_NUL;
			end
		endcase
	end

	assign take   = !empty && (!out_valid_q || !out_stall);
	assign at_end = (idx_q == last_idx);
	assign pop    = take && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= gen_byte;
			out_has_q  <= (head.kind != ste_pkg::KIND_END);
			out_last_q <= head.last && at_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_has_byte = out_has_q;
	assign out_last     = out_last_q;

endmodule

// ===== rtl/core/speech_text_escaper.sv =====
// Top level of the speech text escaper: front, command queue and back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------
//   in       | in_valid / in_stall | in_byte, in_last
//   out      | out_valid/out_stall | out_byte, out_has_byte, out_last
//   config   | cfg_write           | cfg_data (annotation mode)
//
// The front takes one byte per cycle unless the queue is full; a final byte
// holds the input while the window of up to three bytes is worked off.
// The back writes one output byte per cycle unless the output stalls; an item
// expands to one to four output bytes, set by its escape form.
// A result is held in a queue slot, then in the back's output register.
// Reset clears the window, the queue and the output register at once.
// A stalled output lets the queue fill; the input stalls when it is full.
`timescale 1ns / 1ps

module speech_text_escaper #(
	parameter int QUEUE_DEPTH = ste_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_has_byte,
	output logic       out_last
);

	logic          q_full;
	logic          q_push;
	ste_pkg::cmd_t q_cmd;
	logic          q_pop;
	logic          q_empty;
	ste_pkg::cmd_t q_head;

	ste_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	ste_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	ste_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.empty        (q_empty),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.out_has_byte (out_has_byte),
		.out_last     (out_last)
	);

endmodule

// ===== rtl/core/ste_checker.sv =====
// Port-level checks of the speech text escaper, bound to the top level.
`timescale 1ns / 1ps

module ste_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_has_byte,
	input logic       out_last
);

	// A stalled result request stays offered.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// A stalled result request keeps its payload.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_byte) && $stable(out_has_byte) &&
			$stable(out_last))
		else $error("output payload changed while stalled");

	// An end marker is always the final result of a text and carries a zero byte.
	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_has_byte |-> out_last && out_byte == 8'd0)
		else $error("malformed end marker");

	// After the final byte of a text the input pauses while the window drains.
	a_flush_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_last |=> in_stall)
		else $error("input taken right after a final byte");

endmodule

bind speech_text_escaper ste_checker u_ste_checker (.*);

// ===== tb/sv/speech_text_escaper_checker.sv =====
// Predicts the prepared text of the speech text escaper and checks every output request.
`timescale 1ns / 1ps

module speech_text_escaper_checker
	import ste_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       out_has_byte,
	input  logic       out_last,
	output int         fail_count,
	output int         waiting
);

	localparam int MAX_BURST = 12;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       last;
	} prepared_t;

	prepared_t  prepared_q[$];
	logic [7:0] burst[$];

	// Cleaned bytes still waiting for their two bytes of lookahead.
	logic [7:0] window[0:1] = '{8'h00, 8'h00};
	int         window_fill = 0;
	logic [7:0] kept_prev = 8'h00;
	logic       fresh_text = 1'b1;
	logic       skip_next = 1'b0;
	logic       annot = 1'b0;
	int         mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic clear_text();
		window[0] = 8'h00;
		window[1] = 8'h00;
		window_fill = 0;
		kept_prev = 8'h00;
		fresh_text = 1'b1;
		skip_next = 1'b0;
	endtask

	function automatic logic [7:0] scrub(input logic [7:0] c);
		if (c < 8'd32 && c != CH_NL) return CH_SP;
		if (c == 8'd127) return CH_SP;
		if (c == 8'd145 || c == 8'd146) return CH_APOS;
		if ((c >= 8'd129 && c <= 8'd132) || (c >= 8'd134 && c <= 8'd137) || c == 8'd139
		    || (c >= 8'd141 && c <= 8'd144) || c == 8'd155
		    || (c >= 8'd157 && c <= 8'd159) || c == 8'd255)
			return CH_SP;
		return c;
	endfunction

	task automatic put_byte(input logic [7:0] c);
		if (burst.size() < MAX_BURST) burst.push_back(c);
	endtask

	task automatic put_escaped(input logic [7:0] c);
		if (c == CH_PIPE || c == CH_BTICK) begin
			put_byte(CH_BSL);
			put_byte(c);
			put_byte(CH_SP);
		end else if (c == CH_CARET) begin
			put_byte(CH_BSL);
			put_byte(CH_BSL);
			put_byte(CH_CARET);
			put_byte(CH_SP);
		end else if (c == CH_BSL) begin
			repeat (4) put_byte(CH_BSL);
		end else begin
			put_byte(c);
		end
	endtask

	// Works off the head of the window, given the two bytes behind it.
	task automatic expand_head(input logic [7:0] head, input logic [7:0] next1,
	                           input logic [7:0] next2);
		logic [7:0] h;
		h = head;
		if (skip_next) begin
			skip_next = 1'b0;
			kept_prev = h;
			fresh_text = 1'b0;
			return;
		end
		if (h == CH_NL) begin
			// A newline right after a kept space vanishes.
			if (!fresh_text && kept_prev == CH_SP) begin
				kept_prev = CH_NL;
				return;
			end
			h = CH_SP;
		end
		fresh_text = 1'b0;
		kept_prev = h;
		if (annot && h == CH_BSL && (next1 == CH_BSL || next1 == CH_BTICK)) begin
			skip_next = 1'b1;
			put_escaped(next1);
			return;
		end
		if (annot && h == CH_BTICK) begin
			if (next1 == CH_G || next1 == CH_I || (next1 == CH_U && next2 == CH_I)) begin
				put_byte(CH_BSL);
				put_byte(CH_BTICK);
				put_byte(CH_SP);
			end else begin
				put_byte(CH_BTICK);
			end
			return;
		end
		put_escaped(h);
	endtask

	task automatic absorb(input logic [7:0] raw, input logic final_byte);
		logic [7:0] w[0:2];
		int         n;
		prepared_t  p;
		w[0] = window[0];
		w[1] = window[1];
		w[2] = 8'h00;
		n = window_fill;
		w[n] = scrub(raw);
		n++;
		burst.delete();
		if (!final_byte) begin
			if (n == 3) begin
				expand_head(w[0], w[1], w[2]);
				w[0] = w[1];
				w[1] = w[2];
				n = 2;
			end
			window[0] = w[0];
			window[1] = (n > 1) ? w[1] : 8'h00;
			window_fill = n;
			foreach (burst[k]) begin
				p = '{data: burst[k], has_byte: 1'b1, last: 1'b0};
				prepared_q.push_back(p);
			end
		end else begin
			while (n > 0) begin
				expand_head(w[0], (n > 1) ? w[1] : 8'h00, (n > 2) ? w[2] : 8'h00);
				w[0] = w[1];
				w[1] = w[2];
				n--;
			end
			clear_text();
			if (burst.size() == 0) begin
				p = '{data: CH_NUL, has_byte: 1'b0, last: 1'b1};
				prepared_q.push_back(p);
			end else begin
				foreach (burst[k]) begin
					p = '{data: burst[k], has_byte: 1'b1, last: (k == burst.size() - 1)};
					prepared_q.push_back(p);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		prepared_t p;
		if (!arst_n) begin
			prepared_q.delete();
			clear_text();
			annot = 1'b0;
			waiting <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (prepared_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result byte %02h has %b last %b",
						out_byte, out_has_byte, out_last));
				end else begin
					p = prepared_q.pop_front();
					if (out_byte !== p.data)
						report_mismatch($sformatf("out_byte expected %02h got %02h",
							p.data, out_byte));
					if (out_has_byte !== p.has_byte)
						report_mismatch($sformatf("out_has_byte expected %b got %b",
							p.has_byte, out_has_byte));
					if (out_last !== p.last)
						report_mismatch($sformatf("out_last expected %b got %b",
							p.last, out_last));
				end
			end
			if (cfg_write) annot = cfg_data;
			if (in_valid && !in_stall) absorb(in_byte, in_last);
			waiting <= prepared_q.size();
		end
	end

endmodule

// ===== tb/sv/speech_text_escaper_tb.sv =====
// Testbench top of the speech text escaper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module speech_text_escaper_tb;
	import ste_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_BYTES = 480;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 150;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write = 1'b0;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_has_byte;
	logic       out_last;

	int   fail_count;
	int   waiting;
	int   cycles = 0;
	int   bytes_sent = 0;
	int   steady_left = 0;
	logic hold_due = 1'b0;

	logic [7:0] text_q[$];

	speech_text_escaper dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.in_last      (in_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.out_has_byte (out_has_byte),
		.out_last     (out_last)
	);

	speech_text_escaper_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.in_last      (in_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.out_has_byte (out_has_byte),
		.out_last     (out_last),
		.fail_count   (fail_count),
		.waiting      (waiting)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("speech_text_escaper_tb failed");
			$finish;
		end
	end

	// Output side: open stretches, short stalls, a few long ones, and one long
	// hold-off once the random part asks for it.
	initial begin
		int  r;
		int  span;
		logic level;
		logic held;
		held = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_due && !held) begin
				held = 1'b1;
				level = 1'b1;
				span = LONG_HOLD;
			end else if (r < 30) begin
				level = 1'b0;
				span = $urandom_range(10, 40);
			end else if (r < 80) begin
				level = 1'($urandom_range(0, 1));
				span = $urandom_range(1, 3);
			end else if (r < 95) begin
				level = 1'b1;
				span = $urandom_range(4, 8);
			end else begin
				level = 1'b1;
				span = $urandom_range(15, 40);
			end
			out_stall <= level;
			repeat (span) @(posedge clk);
		end
	end

	function automatic int pick_gap();
		int r;
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 8) begin
			steady_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_char();
		int         r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 35) c = 8'($urandom_range(0, 255));
		else if (r < 45) c = 8'($urandom_range(0, 31));
		else if (r < 52) c = 8'($urandom_range(127, 159));
		else begin
			case ($urandom_range(0, 11))
				0: c = CH_BSL;
				1: c = CH_BTICK;
				2: c = CH_PIPE;
				3: c = CH_CARET;
				4: c = CH_NL;
				5: c = CH_SP;
				6: c = CH_G;
				7: c = CH_I;
				8: c = CH_U;
				9: c = 8'd145;
				10: c = 8'd146;
				default: c = 8'hFF;
			endcase
		end
		return c;
	endfunction

	// Called at a rising edge; returns at the edge that accepts the request.
	task automatic push_byte(input logic [7:0] b, input logic final_byte);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= final_byte;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[k]) push_byte(text_q[k], k == text_q.size() - 1);
		text_q.delete();
	endtask

	// Lets every expected result arrive, then gives the block time to go idle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic mode);
		drain();
		cfg_write <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Mostly well-formed annotation and escape patterns with random filler.
	task automatic build_random_text();
		int len;
		len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(12, 30);
		while (text_q.size() < len) begin
			if ($urandom_range(0, 99) < 35) begin
				case ($urandom_range(0, 7))
					0: begin text_q.push_back(CH_BTICK); text_q.push_back(CH_G); end
					1: begin text_q.push_back(CH_BTICK); text_q.push_back(CH_I); end
					2: begin
						text_q.push_back(CH_BTICK);
						text_q.push_back(CH_U);
						text_q.push_back(CH_I);
					end
					3: begin
						text_q.push_back(CH_BTICK);
						text_q.push_back(CH_U);
						text_q.push_back(pick_char());
					end
					4: begin text_q.push_back(CH_BSL); text_q.push_back(CH_BSL); end
					5: begin text_q.push_back(CH_BSL); text_q.push_back(CH_BTICK); end
					6: begin
						text_q.push_back(CH_SP);
						text_q.push_back(CH_NL);
						text_q.push_back(CH_NL);
					end
					default: begin text_q.push_back(CH_NL); text_q.push_back(CH_NL); end
				endcase
			end else begin
				text_q.push_back(pick_char());
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Annotation mode is off after reset.
		text_q = '{8'h00, 8'hFF, CH_PIPE, CH_BTICK, CH_CARET, CH_BSL, 8'd145, 8'd155};
		send_text();
		text_q = '{CH_NL};
		send_text();
		text_q = '{8'd127, CH_NL, CH_NL};
		send_text();

		set_mode(1'b1);
		text_q = '{CH_BSL, CH_BSL, CH_BSL, CH_BTICK, CH_BTICK, CH_G,
		           CH_BTICK, CH_U, CH_I, CH_BTICK, 8'd146};
		send_text();

		// The mode flips while two bytes still wait for lookahead.
		push_byte(CH_BSL, 1'b0);
		push_byte(CH_BTICK, 1'b0);
		set_mode(1'b0);
		push_byte(CH_I, 1'b1);

		bytes_sent = 0;
		hold_due <= 1'b1;
		while (bytes_sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 99) < 15) set_mode(1'($urandom_range(0, 1)));
			build_random_text();
			send_text();
		end

		drain();
		if (fail_count == 0 && waiting == 0) begin
			$display("speech_text_escaper_tb passed");
		end else begin
			$display("speech_text_escaper_tb failed");
		end
		$finish;
	end

endmodule
